### rtl/square_wave_partial_sum_defines.svh
// Assertion macros for the square wave partial sum block.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef SQUARE_WAVE_PARTIAL_SUM_DEFINES_SVH
`define SQUARE_WAVE_PARTIAL_SUM_DEFINES_SVH

// ante holds -> cons holds in the same cycle
`define SWPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define SWPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/swps_pkg.sv
// Shared constants and types for the square wave partial sum block.
// No dependencies.
package swps_pkg;

  localparam int unsigned COL_W     = 10;  // column field
  localparam int unsigned COUNT_W   = 7;   // harmonic_count register
  localparam int unsigned AMP_W     = 18;  // amplitude_scale register
  localparam int unsigned SIN_W     = 15;  // Q0.15 sine magnitude
  localparam int unsigned PROD_W    = AMP_W + SIN_W;
  localparam int unsigned ROW_W     = 9;   // row fields
  localparam int unsigned ROW_SHIFT = 23;  // 2^-23 row units
  localparam int unsigned DIV_BPS   = 4;   // quotient bits per divider stage
  localparam int unsigned MID_DEPTH = 2;   // front-to-back queue
  localparam int unsigned OUT_DEPTH = 4;   // result queue

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SIN_MAX     = 64'd32767;

  // per-harmonic token flags carried down the back pipeline
  typedef struct packed {
    logic first;  // first harmonic of a column
    logic last;   // last harmonic of a column
    logic zero;   // no harmonics: token adds nothing
    logic neg;    // sine negative: term is added positive
  } tok_flags_t;

  typedef struct packed {
    logic [ROW_W-1:0] sum_row;
    logic [ROW_W-1:0] last_term_row;
    logic             clipped;
  } res_t;

endpackage

### rtl/swps_front.sv
// Front end: accepts a column, reduces it modulo half the plot width by reciprocal
// multiplication, and hands phase, phase step and term count to the back end. Uses swps_pkg.
module swps_front
  import swps_pkg::*;
#(
  parameter int unsigned PLOT_WIDTH = 1024,
  parameter int unsigned MAX_TERMS  = 64,
  localparam int unsigned H       = PLOT_WIDTH / 2,
  localparam int unsigned HW      = $clog2(H),
  localparam int unsigned NW      = $clog2(MAX_TERMS + 1),
  localparam int unsigned ENTRY_W = NW + 2 * HW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [COL_W-1:0]   column_i,
  output logic               busy_o,
  input  logic [COUNT_W-1:0] cfg_count_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output logic [ENTRY_W-1:0] q_data_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_PUSH   = 2'd2;

  // x mod H: quotient estimate floor(x * floor(2^COL_W / H) / 2^COL_W) is
  // exact or one low for any 10-bit x, so one compare-subtract finishes it
  localparam int unsigned RCP   = (1 << COL_W) / H;
  localparam int unsigned RCP_W = COL_W + 1;
  localparam int unsigned PRD_W = COL_W + RCP_W;
  localparam int unsigned XW    = COL_W + HW + 1;

  localparam logic [HW:0]   HX  = (HW + 1)'(H);
  localparam logic [XW-1:0] HXW = XW'(H);

  logic [1:0]       state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [HW-1:0]    rem_q, rem_d;
  logic [PRD_W-1:0] prod;
  logic [RCP_W-1:0] quo;
  logic [XW-1:0]    diff;
  logic [HW:0]      dbl;
  logic [HW-1:0]    step;
  logic [NW-1:0]    n_terms;

  assign prod = PRD_W'(col_q) * PRD_W'(RCP);
  assign quo  = prod[PRD_W-1:COL_W];
  assign diff = XW'(col_q) - XW'(quo) * HXW;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    rem_d   = rem_q;
    unique case (state_q)
      ST_IDLE: begin
        if (push_i) begin
          col_d   = column_i;
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        rem_d   = (diff >= HXW) ? HW'(diff - HXW) : HW'(diff);
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (!q_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // phase step between odd harmonics: (2x) mod H
  assign dbl  = {rem_q, 1'b0};
  assign step = (dbl >= HX) ? HW'(dbl - HX) : HW'(dbl);

  assign n_terms = (32'(cfg_count_i) > MAX_TERMS) ? NW'(MAX_TERMS) : NW'(cfg_count_i);

  assign busy_o   = (state_q != ST_IDLE);
  assign q_push_o = (state_q == ST_PUSH) & ~q_full_i;
  assign q_data_o = {n_terms, step, rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    rem_q <= rem_d;
  end

endmodule

### rtl/swps_fifo.sv
// Small register FIFO used between the front and back and on the result side.
// No package dependencies.
module swps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

### rtl/swps_div.sv
// Pipelined restoring divider: product / odd multiplier, DIV_BPS quotient bits
// per stage, one new division per cycle. Uses swps_pkg.
module swps_div
  import swps_pkg::*;
#(
  parameter int unsigned MW = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_vld_i,
  input  logic [PROD_W-1:0] in_num_i,
  input  logic [MW-1:0]     in_den_i,
  input  tok_flags_t        in_flags_i,
  output logic              out_vld_o,
  output logic [PROD_W-1:0] out_quo_o,
  output tok_flags_t        out_flags_o
);

  localparam int unsigned STAGES = (PROD_W + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned PAD_W  = STAGES * DIV_BPS;

  logic             vld_q   [STAGES];
  logic [MW-1:0]    rem_q   [STAGES];
  logic [PAD_W-1:0] num_q   [STAGES];
  logic [PAD_W-1:0] quo_q   [STAGES];
  logic [MW-1:0]    den_q   [STAGES];
  tok_flags_t       flags_q [STAGES];

  logic             vld_in   [STAGES];
  logic [MW-1:0]    rem_in   [STAGES];
  logic [PAD_W-1:0] num_in   [STAGES];
  logic [PAD_W-1:0] quo_in   [STAGES];
  logic [MW-1:0]    den_in   [STAGES];
  tok_flags_t       flags_in [STAGES];

  logic [MW-1:0]    rem_nx [STAGES];
  logic [PAD_W-1:0] num_nx [STAGES];
  logic [PAD_W-1:0] quo_nx [STAGES];

  always_comb begin
    vld_in[0]   = in_vld_i;
    rem_in[0]   = '0;
    num_in[0]   = PAD_W'(in_num_i);
    quo_in[0]   = '0;
    den_in[0]   = in_den_i;
    flags_in[0] = in_flags_i;
    for (int s = 1; s < STAGES; s++) begin
      vld_in[s]   = vld_q[s-1];
      rem_in[s]   = rem_q[s-1];
      num_in[s]   = num_q[s-1];
      quo_in[s]   = quo_q[s-1];
      den_in[s]   = den_q[s-1];
      flags_in[s] = flags_q[s-1];
    end
  end

  always_comb begin : stage_math
    logic [MW:0]      trial;
    logic [MW-1:0]    rem;
    logic [PAD_W-1:0] num;
    logic [PAD_W-1:0] quo;
    for (int s = 0; s < STAGES; s++) begin
      rem = rem_in[s];
      num = num_in[s];
      quo = quo_in[s];
      for (int b = 0; b < DIV_BPS; b++) begin
        trial = {rem, num[PAD_W-1]};
        num   = num << 1;
        if (trial >= {1'b0, den_in[s]}) begin
          rem = MW'(trial - {1'b0, den_in[s]});
          quo = {quo[PAD_W-2:0], 1'b1};
        end else begin
          rem = trial[MW-1:0];
          quo = {quo[PAD_W-2:0], 1'b0};
        end
      end
      rem_nx[s] = rem;
      num_nx[s] = num;
      quo_nx[s] = quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        vld_q[s] <= vld_in[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < STAGES; s++) begin
      rem_q[s]   <= rem_nx[s];
      num_q[s]   <= num_nx[s];
      quo_q[s]   <= quo_nx[s];
      den_q[s]   <= den_in[s];
      flags_q[s] <= flags_in[s];
    end
  end

  assign out_vld_o   = vld_q[STAGES-1];
  assign out_quo_o   = quo_q[STAGES-1][PROD_W-1:0];
  assign out_flags_o = flags_q[STAGES-1];

endmodule

### rtl/swps_back.sv
// Back end: issues one harmonic per cycle through the sine ROM, the amplitude
// multiplier and swps_div, then accumulates and saturates the rows. Uses swps_pkg.
module swps_back
  import swps_pkg::*;
#(
  parameter int unsigned PLOT_WIDTH  = 1024,
  parameter int unsigned PLOT_HEIGHT = 512,
  parameter int unsigned MAX_TERMS   = 64,
  localparam int unsigned H       = PLOT_WIDTH / 2,
  localparam int unsigned HW      = $clog2(H),
  localparam int unsigned NW      = $clog2(MAX_TERMS + 1),
  localparam int unsigned ENTRY_W = NW + 2 * HW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  logic [ENTRY_W-1:0] q_data_i,
  output logic               q_pop_o,
  input  logic [AMP_W-1:0]   cfg_amp_i,
  input  logic               res_pop_i,
  output logic               res_push_o,
  output res_t               res_o
);

  localparam int unsigned AW    = $clog2(H + 1);
  localparam int unsigned MW    = $clog2(2 * MAX_TERMS);
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int unsigned ACC_W = PROD_W + $clog2(MAX_TERMS + 1) + 2;
  localparam int unsigned RW    = ACC_W - ROW_SHIFT;
  localparam int unsigned FW    = HW + 2;

  localparam logic [HW:0]   HX = (HW + 1)'(H);
  localparam logic [FW-1:0] H1 = FW'(H);
  localparam logic [FW-1:0] H2 = FW'(2 * H);
  localparam logic [FW-1:0] H3 = FW'(3 * H);
  localparam logic signed [ACC_W-1:0] CENTRE = ACC_W'(PLOT_HEIGHT / 2) << ROW_SHIFT;

  // quarter-wave sine table, Q0.15, built at elaboration from a Q2.30 series
  logic [SIN_W-1:0] sin_tab [H+1];

  for (genvar g = 0; g <= H; g++) begin : g_tab
    localparam longint unsigned A  = (64'(g) * HALF_PI_Q30) / H;
    localparam longint unsigned A2 = (A * A) >> 30;
    localparam longint unsigned T1 = ((A * A2) >> 30) / 6;
    localparam longint unsigned T2 = ((T1 * A2) >> 30) / 20;
    localparam longint unsigned T3 = ((T2 * A2) >> 30) / 42;
    localparam longint unsigned T4 = ((T3 * A2) >> 30) / 72;
    localparam longint unsigned T5 = ((T4 * A2) >> 30) / 110;
    localparam longint unsigned T6 = ((T5 * A2) >> 30) / 156;
    localparam longint SS = longint'(A) - longint'(T1) + longint'(T2) - longint'(T3)
                          + longint'(T4) - longint'(T5) + longint'(T6);
    localparam longint unsigned SC = (SS < 0) ? 64'd0 : 64'(SS);
    localparam longint unsigned QR = (SC + 64'd16384) >> 15;
    localparam longint unsigned QC = (QR > SIN_MAX) ? SIN_MAX : QR;
    assign sin_tab[g] = SIN_W'(QC);
  end

  // ---------------- issuer ----------------
  logic             act_q;
  logic [CNT_W-1:0] cnt_q;
  logic [HW-1:0]    p_q, d_q, p_next;
  logic [NW-1:0]    left_q;
  logic [MW-1:0]    m_q;
  logic             first_q, zero_q;
  logic             load, tok_last;
  logic [HW-1:0]    e_p, e_d;
  logic [NW-1:0]    e_n;
  logic [HW:0]      p_sum;

  assign e_p = q_data_i[HW-1:0];
  assign e_d = q_data_i[2*HW-1:HW];
  assign e_n = q_data_i[ENTRY_W-1:2*HW];

  // a column starts only when its result has a guaranteed slot downstream
  assign load     = ~act_q & ~q_empty_i & (cnt_q < CNT_W'(OUT_DEPTH));
  assign q_pop_o  = load;
  assign tok_last = (left_q <= NW'(1));

  assign p_sum  = {1'b0, p_q} + {1'b0, d_q};
  assign p_next = (p_sum >= HX) ? HW'(p_sum - HX) : HW'(p_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (load) begin
        act_q <= 1'b1;
      end else if (act_q && tok_last) begin
        act_q <= 1'b0;
      end
      if (load && !res_pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (res_pop_i && !load) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      p_q     <= e_p;
      d_q     <= e_d;
      left_q  <= e_n;
      m_q     <= MW'(1);
      first_q <= 1'b1;
      zero_q  <= (e_n == '0);
    end else if (act_q) begin
      p_q     <= p_next;
      left_q  <= left_q - NW'(1);
      m_q     <= m_q + MW'(2);
      first_q <= 1'b0;
    end
  end

  // ---------------- quadrant and ROM ----------------
  logic [FW-1:0]    f, r;
  logic [1:0]       quad;
  logic [AW-1:0]    addr;
  logic [SIN_W-1:0] rom_q;

  always_comb begin
    f = {p_q, 2'b00};
    priority if (f >= H3) begin
      quad = 2'd3;
      r    = f - H3;
    end else if (f >= H2) begin
      quad = 2'd2;
      r    = f - H2;
    end else if (f >= H1) begin
      quad = 2'd1;
      r    = f - H1;
    end else begin
      quad = 2'd0;
      r    = f;
    end
    addr = quad[0] ? AW'(H1 - r) : AW'(r);
  end

  always_ff @(posedge clk_i) begin
    rom_q <= sin_tab[addr];
  end

  // ---------------- stage 1 / stage 2 ----------------
  logic              s1_vld_q, s2_vld_q;
  logic [MW-1:0]     s1_m_q, s2_m_q;
  tok_flags_t        s1_flags_q, s2_flags_q;
  logic [PROD_W-1:0] s2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= act_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_m_q           <= m_q;
    s1_flags_q.first <= first_q;
    s1_flags_q.last  <= tok_last;
    s1_flags_q.zero  <= zero_q;
    s1_flags_q.neg   <= quad[1];
    s2_m_q           <= s1_m_q;
    s2_flags_q       <= s1_flags_q;
    s2_prod_q        <= PROD_W'(cfg_amp_i) * PROD_W'(rom_q);
  end

  // ---------------- divider ----------------
  logic              dv_vld;
  logic [PROD_W-1:0] dv_quo;
  tok_flags_t        dv_flags;

  swps_div #(
    .MW (MW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (s2_vld_q),
    .in_num_i    (s2_prod_q),
    .in_den_i    (s2_m_q),
    .in_flags_i  (s2_flags_q),
    .out_vld_o   (dv_vld),
    .out_quo_o   (dv_quo),
    .out_flags_o (dv_flags)
  );

  // ---------------- accumulate ----------------
  logic signed [ACC_W-1:0] mag, term, acc_q, acc_d, fin_acc_q, fin_last_q;
  logic                    fin_vld_q;

  always_comb begin
    mag = signed'(ACC_W'(dv_quo));
    if (dv_flags.zero) begin
      term = '0;
    end else if (dv_flags.neg) begin
      term = mag;
    end else begin
      term = -mag;
    end
    acc_d = dv_flags.first ? term : acc_q + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else begin
      fin_vld_q <= dv_vld & dv_flags.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_vld) begin
      acc_q <= acc_d;
    end
    if (dv_vld && dv_flags.last) begin
      fin_acc_q  <= acc_d;
      fin_last_q <= term;
    end
  end

  // ---------------- rows ----------------
  function automatic logic [ROW_W:0] to_row(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] total;
    logic [RW-1:0]           rw;
    total = CENTRE + v;
    rw    = total[ACC_W-1:ROW_SHIFT];
    if (total < 0) begin
      return {1'b1, ROW_W'(0)};
    end
    if (rw > RW'(PLOT_HEIGHT - 1)) begin
      return {1'b1, ROW_W'(PLOT_HEIGHT - 1)};
    end
    return {1'b0, rw[ROW_W-1:0]};
  endfunction

  logic [ROW_W:0] row_sum, row_last;

  assign row_sum  = to_row(fin_acc_q);
  assign row_last = to_row(fin_last_q);

  assign res_push_o          = fin_vld_q;
  assign res_o.sum_row       = row_sum[ROW_W-1:0];
  assign res_o.last_term_row = row_last[ROW_W-1:0];
  assign res_o.clipped       = row_sum[ROW_W] | row_last[ROW_W];

endmodule

### rtl/square_wave_partial_sum.sv
// Square wave partial Fourier sum for one plot column: queue-style input and
// result channels, APB register port. Uses swps_pkg, swps_front, swps_fifo,
// swps_back (with swps_div) and square_wave_partial_sum_defines.svh.
//
// Each column x gets the sum of -amplitude*sin(m*x*pi/(PLOT_WIDTH/4))/m over
// the odd harmonics m = 1, 3, ... (harmonic_count of them, capped at MAX_TERMS)
// on top of the centre row, plus the row of the last term alone; both rows
// saturate to 0..PLOT_HEIGHT-1 and set clipped. The front end reduces a
// column modulo half the width by a reciprocal multiply, hands it into a
// two-entry queue (waiting while that queue is full) and goes back to idle;
// full is high meanwhile, so it takes no new column before that. The back
// end starts a column once the queue has an entry and a result slot is free,
// then issues one harmonic per cycle through the sine ROM, the 18x15
// multiplier and a 9-stage pipelined divider, one token per harmonic (a single
// token when there are no harmonics), with no stall within a column. At most
// four columns are in flight past the queue, matching the result queue depth,
// so a slow result reader stalls the back end and then the front end. The sine
// table is a constant ROM; there is no clearing pass after reset.
// Registers: harmonic_count at 0x0 (reset 1), amplitude_scale at 0x4
// (reset 46811, units of 1/256 row). Write them only while the block is idle.
`include "square_wave_partial_sum_defines.svh"

module square_wave_partial_sum
  import swps_pkg::*;
#(
  parameter int unsigned PLOT_WIDTH  = 1024,
  parameter int unsigned PLOT_HEIGHT = 512,
  parameter int unsigned MAX_TERMS   = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             push,
  output logic             full,
  input  logic [COL_W-1:0] column_i,
  // result channel
  output logic             empty,
  input  logic             pop,
  output logic [ROW_W-1:0] sum_row_o,
  output logic [ROW_W-1:0] last_term_row_o,
  output logic             clipped_o,
  // register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned H       = PLOT_WIDTH / 2;
  localparam int unsigned HW      = $clog2(H);
  localparam int unsigned NW      = $clog2(MAX_TERMS + 1);
  localparam int unsigned ENTRY_W = NW + 2 * HW;

  // register index, taken from the word address bit
  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_AMP   = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1);
  localparam logic [AMP_W-1:0]   AMP_RST   = AMP_W'(46811);

  // ---------------- registers ----------------
  logic [COUNT_W-1:0] count_q;
  logic [AMP_W-1:0]   amp_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RST;
      amp_q   <= AMP_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_COUNT: count_q <= pwdata[COUNT_W-1:0];
        REG_AMP:   amp_q   <= pwdata[AMP_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COUNT: prdata = 32'(count_q);
      REG_AMP:   prdata = 32'(amp_q);
      default:   prdata = '0;
    endcase
  end

  // ---------------- front end ----------------
  logic               mid_push, mid_full, mid_pop, mid_empty;
  logic [ENTRY_W-1:0] mid_wdata, mid_rdata;
  logic               in_take;

  assign in_take = push & ~full;

  swps_front #(
    .PLOT_WIDTH (PLOT_WIDTH),
    .MAX_TERMS  (MAX_TERMS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_take),
    .column_i    (column_i),
    .busy_o      (full),
    .cfg_count_i (count_q),
    .q_full_i    (mid_full),
    .q_push_o    (mid_push),
    .q_data_o    (mid_wdata)
  );

  // decouples the front from the harmonic pipeline
  swps_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  // ---------------- back end ----------------
  logic res_push, res_full, res_pop;
  res_t res_wdata, res_rdata;

  assign res_pop = pop & ~empty;

  swps_back #(
    .PLOT_WIDTH  (PLOT_WIDTH),
    .PLOT_HEIGHT (PLOT_HEIGHT),
    .MAX_TERMS   (MAX_TERMS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (mid_empty),
    .q_data_i   (mid_rdata),
    .q_pop_o    (mid_pop),
    .cfg_amp_i  (amp_q),
    .res_pop_i  (res_pop),
    .res_push_o (res_push),
    .res_o      (res_wdata)
  );

  // result queue: one slot per column the back end may have in flight
  swps_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_wdata),
    .full_o  (res_full),
    .pop_i   (res_pop),
    .data_o  (res_rdata),
    .empty_o (empty)
  );

  assign sum_row_o       = res_rdata.sum_row;
  assign last_term_row_o = res_rdata.last_term_row;
  assign clipped_o       = res_rdata.clipped;

  // ---------------- assertions ----------------
  // the credit count in the back end must keep the result queue from overflowing
  `SWPS_ASSERT_IMPL(a_res_room, res_push, !res_full, "result written into a full queue")
  // an accepted transaction occupies the front end
  `SWPS_ASSERT_NEXT(a_accept_busy, in_take, full, "front end idle after accepting")
  // after handing a column to the queue the front end is ready again
  `SWPS_ASSERT_NEXT(a_handoff_ready, mid_push, !full, "front end stuck after handoff")

endmodule

### sim/swps_tb_pkg.sv
// Register map shared by the square wave partial sum testbench files.
// No dependencies.
package swps_tb_pkg;

  localparam logic [2:0] REG_HARMONIC_COUNT  = 3'h0;
  localparam logic [2:0] REG_AMPLITUDE_SCALE = 3'h4;

endpackage

### sim/square_wave_partial_sum_checker.sv
// Checker for square_wave_partial_sum: checks register readbacks, follows writes,
// predicts rows per column, checks results in pop order. Uses swps_pkg, swps_tb_pkg.
module square_wave_partial_sum_checker
  import swps_pkg::*;
  import swps_tb_pkg::*;
#(
  parameter int unsigned PLOT_WIDTH  = 1024,
  parameter int unsigned PLOT_HEIGHT = 512,
  parameter int unsigned MAX_TERMS   = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  logic             full,
  input  logic [COL_W-1:0] column_i,
  input  logic             empty,
  input  logic             pop,
  input  logic [ROW_W-1:0] sum_row_o,
  input  logic [ROW_W-1:0] last_term_row_o,
  input  logic             clipped_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic [31:0]      prdata,
  input  logic             pready,
  output int unsigned      mismatch_count,
  output int unsigned      pending
);

  localparam int unsigned HALF_W = PLOT_WIDTH / 2;

  logic [15:0]        sine_rom [0:HALF_W];
  logic [COUNT_W-1:0] harm_count;
  logic [AMP_W-1:0]   amp_scale;
  res_t               expected_rows [$];

  // Quarter-wave sine in Q1.15, Taylor series on a Q2.30 angle.
  function automatic logic [15:0] quarter_sine(int unsigned r);
    longint unsigned ang, ang_sq, term, q;
    longint          acc;
    ang    = (longint'(r) * HALF_PI_Q30) / HALF_W;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = longint'(ang);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * ang_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(term);
      else            acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    q = (longint'(acc) + (1 << 14)) >> 15;
    if (q > SIN_MAX) q = SIN_MAX;
    return q[15:0];
  endfunction

  // {clip, row} for a total in 2^-23 row units
  function automatic logic [ROW_W:0] saturate_row(longint total);
    longint row;
    if (total < 0) return {1'b1, {ROW_W{1'b0}}};
    row = total >>> ROW_SHIFT;
    if (row > longint'(PLOT_HEIGHT - 1)) return {1'b1, ROW_W'(PLOT_HEIGHT - 1)};
    return {1'b0, row[ROW_W-1:0]};
  endfunction

  function automatic res_t predict_rows(logic [COL_W-1:0] x);
    longint          centre, sum_acc, last_term, mag;
    longint unsigned odd, phase, f, quad, rem, sine_mag;
    int unsigned     terms;
    logic [ROW_W:0]  sum_sat, last_sat;
    res_t            r;
    terms     = (harm_count > MAX_TERMS) ? MAX_TERMS : harm_count;
    centre    = longint'(PLOT_HEIGHT / 2) <<< ROW_SHIFT;
    sum_acc   = 0;
    last_term = 0;
    for (int unsigned i = 0; i < terms; i++) begin
      odd      = 2 * i + 1;
      phase    = (odd * x) % HALF_W;
      f        = 4 * phase;
      quad     = (f / HALF_W) & 3;
      rem      = f % HALF_W;
      sine_mag = quad[0] ? sine_rom[HALF_W - rem] : sine_rom[rem];
      mag      = longint'((longint'(amp_scale) * sine_mag) / odd);
      // term goes against the sine
      last_term = quad[1] ? mag : -mag;
      sum_acc  += last_term;
    end
    sum_sat         = saturate_row(centre + sum_acc);
    last_sat        = saturate_row(centre + last_term);
    r.sum_row       = sum_sat[ROW_W-1:0];
    r.last_term_row = last_sat[ROW_W-1:0];
    r.clipped       = sum_sat[ROW_W] | last_sat[ROW_W];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  initial begin
    for (int unsigned r = 0; r <= HALF_W; r++) sine_rom[r] = quarter_sine(r);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      harm_count = COUNT_W'(1);
      amp_scale  = AMP_W'(46811);
      expected_rows.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr)
            REG_HARMONIC_COUNT:  harm_count = pwdata[COUNT_W-1:0];
            REG_AMPLITUDE_SCALE: amp_scale  = pwdata[AMP_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr)
            REG_HARMONIC_COUNT:
              if (prdata !== 32'(harm_count))
                report_mismatch("harmonic_count readback", prdata, harm_count);
            REG_AMPLITUDE_SCALE:
              if (prdata !== 32'(amp_scale))
                report_mismatch("amplitude_scale readback", prdata, amp_scale);
            default: ;
          endcase
        end
      end
      if (push && !full) expected_rows.push_back(predict_rows(column_i));
      if (pop && !empty) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("unexpected result, sum_row", sum_row_o, 0);
        end else begin
          want = expected_rows.pop_front();
          if (sum_row_o !== want.sum_row)
            report_mismatch("sum_row", sum_row_o, want.sum_row);
          if (last_term_row_o !== want.last_term_row)
            report_mismatch("last_term_row", last_term_row_o, want.last_term_row);
          if (clipped_o !== want.clipped)
            report_mismatch("clipped", clipped_o, want.clipped);
        end
      end
      pending <= expected_rows.size();
    end
  end

endmodule

### sim/square_wave_partial_sum_test.sv
// Testbench top for square_wave_partial_sum: clock, reset, register phases,
// column stimulus and result back-pressure. Uses swps_pkg, swps_tb_pkg and the checker.
module square_wave_partial_sum_test;
  import swps_pkg::*;
  import swps_tb_pkg::*;

  // run limit, set with a wide margin over the slowest run
  localparam int unsigned RUN_LIMIT    = 1_000_000;
  // wait this long once nothing is expected
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 108;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic [COL_W-1:0] column_i = '0;
  logic             pop = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;

  logic             full, empty, clipped_o, pready;
  logic [ROW_W-1:0] sum_row_o, last_term_row_o;
  logic [31:0]      prdata;

  int unsigned      mismatch_count, pending;
  int unsigned      cycle_count = 0;
  logic [COL_W-1:0] column_q [$];   // columns waiting to be pushed

  square_wave_partial_sum dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .column_i        (column_i),
    .empty           (empty),
    .pop             (pop),
    .sum_row_o       (sum_row_o),
    .last_term_row_o (last_term_row_o),
    .clipped_o       (clipped_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  square_wave_partial_sum_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .column_i        (column_i),
    .empty           (empty),
    .pop             (pop),
    .sum_row_o       (sum_row_o),
    .last_term_row_o (last_term_row_o),
    .clipped_o       (clipped_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatch_count  (mismatch_count),
    .pending         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: a new stall mode each time the 8-bit stall_tick wraps.
  //   0: always pop   1: coin flip   2: rotating mask   3: pop rarely
  logic [1:0]  stall_mode = 2'd0;
  logic [15:0] stall_mask = 16'hffff;
  logic [7:0]  stall_tick = 8'd0;

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick == 8'd0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_mask <= 16'($urandom) | 16'h0001;
    end
    case (stall_mode)
      2'd0: pop <= 1'b1;
      2'd1: pop <= 1'($urandom_range(0, 1));
      2'd2: pop <= stall_mask[stall_tick[3:0]];
      default: pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // One APB transaction: setup, then access until pready, then back to idle.
  task automatic reg_access(logic is_write, logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Push everything in column_q in bursts; a gap with push low separates
  // bursts, and now and then a long burst runs without gaps.
  task automatic send_columns();
    int unsigned burst;
    while (column_q.size() != 0) begin
      burst = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      while (burst != 0 && column_q.size() != 0) begin
        push     <= 1'b1;
        column_i <= column_q.pop_front();
        @(posedge clk_i);
        while (full) @(posedge clk_i);
        burst--;
      end
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Block is idle once every expected transaction has come back.
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Reprogram both registers while idle, read them back, then run the columns.
  task automatic run_phase(logic [COUNT_W-1:0] terms, logic [AMP_W-1:0] amp);
    wait_idle();
    reg_access(1'b1, REG_HARMONIC_COUNT, 32'(terms));
    reg_access(1'b1, REG_AMPLITUDE_SCALE, 32'(amp));
    reg_access(1'b0, REG_HARMONIC_COUNT, '0);
    reg_access(1'b0, REG_AMPLITUDE_SCALE, '0);
    send_columns();
  endtask

  // Mostly uniform columns; some near multiples of 64, among them the quarter-period
  // points where sines hit zero or their peaks.
  function automatic logic [COL_W-1:0] pick_column();
    if ($urandom_range(0, 3) == 0)
      return COL_W'($urandom_range(0, 15) * 64 + $urandom_range(0, 2));
    return COL_W'($urandom_range(0, 1023));
  endfunction

  initial begin
    logic [COUNT_W-1:0] terms;
    logic [AMP_W-1:0]   amp;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one harmonic, default amplitude; zeros and peaks of the sine
    column_q = '{10'd0, 10'd1, 10'd128, 10'd256, 10'd384, 10'd512, 10'd768,
                 10'd1023, 10'd341};
    send_columns();

    // zero harmonics: both rows stay at the centre
    column_q = '{10'd0, 10'd1023, 10'd300};
    run_phase(COUNT_W'(0), AMP_W'(262143));

    // count above the cap is clamped
    column_q = '{10'd100, 10'd1023};
    run_phase(COUNT_W'(127), AMP_W'(46811));

    // huge fundamental: positive peak drives below 0, negative peak above top
    column_q = '{10'd128, 10'd384, 10'd0};
    run_phase(COUNT_W'(1), AMP_W'(262143));

    // no amplitude with the full harmonic count
    column_q = '{10'd77, 10'd1023};
    run_phase(COUNT_W'(64), AMP_W'(0));

    // everything at maximum
    column_q = '{10'd5, 10'd640, 10'd1000};
    run_phase(COUNT_W'(64), AMP_W'(262143));

    // random phases; the first few pin the register extremes
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin terms = COUNT_W'(0);   amp = AMP_W'($urandom); end
        1: begin terms = COUNT_W'(127); amp = AMP_W'(262143);   end
        2: begin terms = COUNT_W'(1);   amp = AMP_W'(0);        end
        3: begin terms = COUNT_W'(65);  amp = AMP_W'(46811);    end
        default: begin
          terms = ($urandom_range(0, 2) == 0) ? COUNT_W'($urandom_range(0, 127))
                                              : COUNT_W'($urandom_range(1, 16));
          amp   = ($urandom_range(0, 1) == 0) ? AMP_W'($urandom_range(0, 100000))
                                              : AMP_W'($urandom);
        end
      endcase
      repeat (PHASE_ITEMS) column_q.push_back(pick_column());
      run_phase(terms, amp);
    end

    wait_idle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/swps_pkg.sv
rtl/swps_front.sv
rtl/swps_fifo.sv
rtl/swps_div.sv
rtl/swps_back.sv
rtl/square_wave_partial_sum.sv
sim/swps_tb_pkg.sv
sim/square_wave_partial_sum_checker.sv
sim/square_wave_partial_sum_test.sv
